// ===== hdl/kmm_pkg.sv =====
// Shared types, codes and state encoding for the key-to-list multimap.
package kmm_pkg;

	localparam int KEY_W    = 32;
	localparam int COURSE_W = 12;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;
	localparam int CMD_W    = 2;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_REGISTER = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ENROLL   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE     = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_UNKNOWN    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_LIST_FULL  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_DUPLICATE  = 3'd4;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [KEY_W-1:0]    key;
		logic [COURSE_W-1:0] course;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		logic [COURSE_W-1:0] course_out;
		logic                last;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MISS,
		ST_FETCH,
		ST_DECIDE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_WR,
		ST_Q_RD,
		ST_Q_OUT
	} state_t;

endpackage

// ===== hdl/kmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/key_to_list_multimap.sv =====
// Key-to-list multimap: key match by linear scan, sorted insert, list readout.
// A new key, full table or unknown key is reported once the scan misses; a duplicate or full
// list once the count is read; a query of a non-empty list gives one result per listed course,
// in ascending order; enroll moves each larger course up one slot, then writes into the hole.
// Throughput: one request at a time; busy falls in the cycle of the last result (no stall).
// Reset clears the fill count and control state; key, count and list memories need no clearing.
module key_to_list_multimap
	import kmm_pkg::*;
#(
	parameter int TABLE_DEPTH = 256,
	parameter int MAX_LIST    = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t request,
	output logic strobe,
	output rsp_t result
);

	localparam int IW  = $clog2(TABLE_DEPTH);
	localparam int UW  = $clog2(TABLE_DEPTH + 1);
	localparam int CW  = $clog2(MAX_LIST + 1);
	localparam int LD  = TABLE_DEPTH * MAX_LIST;
	localparam int LAW = $clog2(LD);

	state_t state_q, state_d;

	logic [CMD_W-1:0]    cmd_q, cmd_d;
	logic [KEY_W-1:0]    key_q, key_d;
	logic [COURSE_W-1:0] course_q, course_d;
	logic [UW-1:0]       scan_q, scan_d;
	logic                pend_q, pend_d;
	logic [IW-1:0]       idx_q, idx_d;
	logic [LAW-1:0]      base_q, base_d;
	logic [CW-1:0]       cnt_q, cnt_d;
	logic [CW-1:0]       pos_q, pos_d;
	logic [UW-1:0]       used_q, used_d;
	logic                strobe_q;
	rsp_t                result_q;

	logic                emit;
	rsp_t                emit_rsp;

	// Memory ports.
	logic                key_we;
	logic [IW-1:0]       key_waddr;
	logic [KEY_W-1:0]    key_rdata;
	logic                cnt_we;
	logic [IW-1:0]       cnt_waddr;
	logic [CW-1:0]       cnt_wdata;
	logic [CW-1:0]       cnt_rdata;
	logic                lst_we;
	logic [LAW-1:0]      lst_waddr;
	logic [COURSE_W-1:0] lst_wdata;
	logic [LAW-1:0]      lst_raddr;
	logic [COURSE_W-1:0] lst_rdata;

	logic [LAW-1:0]      addr_pos;
	logic [LAW-1:0]      addr_prev;

	assign addr_pos  = LAW'(base_q + LAW'(pos_q));
	assign addr_prev = LAW'(base_q + LAW'(pos_q - CW'(1)));
	assign lst_raddr = (state_q == ST_INS_RD) ? addr_prev : addr_pos;

	kmm_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_q),
		.raddr (scan_q[IW-1:0]),
		.rdata (key_rdata)
	);

	kmm_ram #(.WIDTH(CW), .DEPTH(TABLE_DEPTH)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (idx_q),
		.rdata (cnt_rdata)
	);

	kmm_ram #(.WIDTH(COURSE_W), .DEPTH(LD)) u_list_ram (
		.clk   (clk),
		.we    (lst_we),
		.waddr (lst_waddr),
		.wdata (lst_wdata),
		.raddr (lst_raddr),
		.rdata (lst_rdata)
	);

	// Sequencer: next state, datapath updates and memory controls.
	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		key_d     = key_q;
		course_d  = course_q;
		scan_d    = scan_q;
		pend_d    = pend_q;
		idx_d     = idx_q;
		base_d    = base_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		used_d    = used_q;
		emit      = 1'b0;
		emit_rsp  = '0;
		key_we    = 1'b0;
		key_waddr = used_q[IW-1:0];
		cnt_we    = 1'b0;
		cnt_waddr = idx_q;
		cnt_wdata = '0;
		lst_we    = 1'b0;
		lst_waddr = addr_pos;
		lst_wdata = course_q;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd_d    = request.command;
					key_d    = request.key;
					course_d = request.course;
					scan_d   = '0;
					pend_d   = 1'b0;
					if (request.command != CMD_NONE) begin
						state_d = ST_SCAN;
					end
				end
			end

			// One key read per cycle; the compare sees the entry read in the cycle before.
			ST_SCAN: begin
				if (pend_q && key_rdata == key_q) begin
					idx_d   = IW'(scan_q - UW'(1));
					state_d = ST_FETCH;
				end else if (scan_q < used_q) begin
					scan_d = scan_q + UW'(1);
					pend_d = 1'b1;
				end else begin
					state_d = ST_MISS;
				end
			end

			// Key not present: add it, or report unknown or table full.
			ST_MISS: begin
				emit          = 1'b1;
				emit_rsp.last = 1'b1;
				if (cmd_q == CMD_REGISTER) begin
					if (used_q == UW'(TABLE_DEPTH)) begin
						emit_rsp.status = STAT_TABLE_FULL;
					end else begin
						emit_rsp.status = STAT_OK;
						key_we          = 1'b1;
						cnt_we          = 1'b1;
						cnt_waddr       = used_q[IW-1:0];
						cnt_wdata       = '0;
						used_d          = used_q + UW'(1);
					end
				end else begin
					emit_rsp.status = STAT_UNKNOWN;
				end
				state_d = ST_IDLE;
			end

			// Count read in flight; form the list base address.
			ST_FETCH: begin
				base_d  = LAW'(LAW'(idx_q) * LAW'(MAX_LIST));
				state_d = ST_DECIDE;
			end

			ST_DECIDE: begin
				cnt_d = cnt_rdata;
				pos_d = '0;
				case (cmd_q)
					CMD_REGISTER: begin
						emit            = 1'b1;
						emit_rsp.status = STAT_DUPLICATE;
						emit_rsp.count  = COUNT_W'(cnt_rdata);
						emit_rsp.last   = 1'b1;
						state_d         = ST_IDLE;
					end
					CMD_ENROLL: begin
						if (cnt_rdata >= CW'(MAX_LIST)) begin
							emit            = 1'b1;
							emit_rsp.status = STAT_LIST_FULL;
							emit_rsp.count  = COUNT_W'(CW'(MAX_LIST));
							emit_rsp.last   = 1'b1;
							state_d         = ST_IDLE;
						end else begin
							pos_d   = cnt_rdata;
							state_d = ST_INS_RD;
						end
					end
					default: begin
						if (cnt_rdata == '0) begin
							emit            = 1'b1;
							emit_rsp.status = STAT_OK;
							emit_rsp.last   = 1'b1;
							state_d         = ST_IDLE;
						end else begin
							state_d = ST_Q_RD;
						end
					end
				endcase
			end

			// Sorted insert: read the entry below the hole.
			ST_INS_RD: begin
				if (pos_q == '0) begin
					state_d = ST_INS_WR;
				end else begin
					state_d = ST_INS_CMP;
				end
			end

			// A larger entry moves up one slot; otherwise the hole is found.
			ST_INS_CMP: begin
				if (lst_rdata > course_q) begin
					lst_we    = 1'b1;
					lst_wdata = lst_rdata;
					pos_d     = pos_q - CW'(1);
					state_d   = ST_INS_RD;
				end else begin
					state_d = ST_INS_WR;
				end
			end

			ST_INS_WR: begin
				lst_we          = 1'b1;
				lst_wdata       = course_q;
				cnt_we          = 1'b1;
				cnt_wdata       = cnt_q + CW'(1);
				emit            = 1'b1;
				emit_rsp.status = STAT_OK;
				emit_rsp.count  = COUNT_W'(CW'(cnt_q + CW'(1)));
				emit_rsp.last   = 1'b1;
				state_d         = ST_IDLE;
			end

			ST_Q_RD: begin
				state_d = ST_Q_OUT;
			end

			// One listed course per result.
			ST_Q_OUT: begin
				emit                = 1'b1;
				emit_rsp.status     = STAT_OK;
				emit_rsp.count      = COUNT_W'(cnt_q);
				emit_rsp.course_out = lst_rdata;
				emit_rsp.last       = (pos_q == CW'(cnt_q - CW'(1)));
				pos_d               = pos_q + CW'(1);
				if (pos_q == CW'(cnt_q - CW'(1))) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_Q_RD;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			pend_q   <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			used_q   <= used_d;
			pend_q   <= pend_d;
			strobe_q <= emit;
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		key_q    <= key_d;
		course_q <= course_d;
		scan_q   <= scan_d;
		idx_q    <= idx_d;
		base_q   <= base_d;
		cnt_q    <= cnt_d;
		pos_q    <= pos_d;
		if (emit) begin
			result_q <= emit_rsp;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

endmodule
